// ----- hdl/odic_pkg.sv -----
// shared types and constants of the one-dimensional image convolver
package odic_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int HALF_MAX_DEF  = 3;
  localparam int COEF_FRAC     = 14;
  localparam int MAX_HEIGHT    = 1024;
  localparam int ROW_W         = $clog2(MAX_HEIGHT);
  localparam int PIX_W         = 24;
  localparam int CH_W          = 8;
  localparam int COEF_W        = 16;
  localparam int DIM_W         = 11;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH     = 3'd0,
    REG_HEIGHT    = 3'd1,
    REG_DIRECTION = 3'd2,
    REG_HALF      = 3'd3,
    REG_COEF_LO   = 3'd4,
    REG_COEF_HI   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              not_empty;
  } q_stat_t;

endpackage

// ----- hdl/odic_bank.sv -----
// one row bank of the line store: one write and one registered read per cycle
module odic_bank #(
  parameter int DEPTH = odic_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(DEPTH)-1:0]     waddr_i,
  input  logic [odic_pkg::PIX_W-1:0]   wdata_i,
  input  logic [$clog2(DEPTH)-1:0]     raddr_i,
  output logic [odic_pkg::PIX_W-1:0]   rdata_o
);

  logic [odic_pkg::PIX_W-1:0] mem_q [DEPTH];
  logic [odic_pkg::PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/odic_front.sv -----
// front end: geometry registers, counters, row window, line store and job issue
module odic_front #(
  parameter int MAX_WIDTH = odic_pkg::MAX_WIDTH_DEF,
  parameter int HALF_MAX  = odic_pkg::HALF_MAX_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  odic_pkg::cfg_wr_t                         cfg_i,
  input  logic                                      s_valid_i,
  output logic                                      s_ready_o,
  input  logic                                      cmd_i,
  input  logic [odic_pkg::PIX_W-1:0]                pix_i,
  input  odic_pkg::q_stat_t                         q_stat_i,
  output logic                                      push_o,
  output logic [(2*HALF_MAX+1)*odic_pkg::PIX_W:0]   job_o
);

  localparam int WIN   = 2 * HALF_MAX + 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int BW    = $clog2(WIN);
  localparam int ROW_W = odic_pkg::ROW_W;
  localparam int TW    = (CW > ROW_W) ? CW : ROW_W;
  localparam int PW    = odic_pkg::PIX_W;

  // configuration
  logic [odic_pkg::DIM_W-1:0] width_q, height_q;
  logic                       dir_q;
  logic [1:0]                 half_q;
  logic                       geo_wr;

  // control state
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [BW-1:0]    rmod_q, rmod_d;
  logic             drain_act_q, drain_act_d;
  logic [CW-1:0]    drain_col_q, drain_col_d;
  logic [1:0]       drain_rel_q, drain_rel_d;
  logic [BW-1:0]    tmod_q, tmod_d;
  logic             seq_act_q, seq_act_d;
  logic [1:0]       seq_rel_q, seq_rel_d;
  logic             b_valid_q;

  // row window and stage b payload
  logic [PW-1:0] win_q   [WIN];
  logic [PW-1:0] win_now [WIN];
  logic [PW-1:0] win_src [WIN];
  logic [PW-1:0] b_hs_q  [WIN];
  logic [BW-1:0] b_bank_q[WIN];
  logic          b_byp_q [WIN];
  logic          b_mask_q[WIN];
  logic          b_horiz_q, b_last_q;
  logic [PW-1:0] b_pix_q;

  logic [CW-1:0]    col_last;
  logic [ROW_W-1:0] row_last;
  logic [1:0]       h_eff, rel_start;
  logic             space, acc, is_pix, frame_end, wr_en;
  logic             iss_valid, iss_horiz, iss_live, iss_last;
  logic [1:0]       iss_rel;
  logic [TW-1:0]    iss_top;
  logic [BW-1:0]    iss_tmod;
  logic [CW-1:0]    rd_col;
  logic [BW:0]      sum_rh;
  logic [BW-1:0]    tap_dist [WIN];
  logic [BW-1:0]    bank   [WIN];
  logic             mask   [WIN];
  logic [PW-1:0]    hsamp  [WIN];
  logic [PW-1:0]    rd_data[WIN];

  assign geo_wr = cfg_i.we && (cfg_i.idx == odic_pkg::REG_WIDTH ||
                               cfg_i.idx == odic_pkg::REG_HEIGHT ||
                               cfg_i.idx == odic_pkg::REG_DIRECTION ||
                               cfg_i.idx == odic_pkg::REG_HALF);

  always_comb begin
    if (width_q == '0) begin
      col_last = '0;
    end else if (32'(width_q) > MAX_WIDTH) begin
      col_last = CW'(MAX_WIDTH - 1);
    end else begin
      col_last = CW'(width_q - 11'd1);
    end
    if (height_q == '0) begin
      row_last = '0;
    end else if (32'(height_q) > odic_pkg::MAX_HEIGHT) begin
      row_last = ROW_W'(odic_pkg::MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_W'(height_q - 11'd1);
    end
    h_eff = (32'(half_q) > HALF_MAX) ? 2'(HALF_MAX) : half_q;
  end

  // room for the beat in stage b plus one more
  assign space     = (32'(q_stat_i.count) + 32'(b_valid_q)) < odic_pkg::QUEUE_DEPTH;
  assign s_ready_o = space && !seq_act_q;
  assign acc       = s_valid_i && s_ready_o;
  assign is_pix    = (cmd_i == odic_pkg::CMD_PIXEL);
  assign frame_end = (col_q == col_last) && (row_q == row_last);

  always_comb begin
    win_now[0] = pix_i;
    for (int t = 1; t < WIN; t++) begin
      win_now[t] = win_q[t-1];
    end
    for (int t = 0; t < WIN; t++) begin
      win_src[t] = seq_act_q ? win_q[t] : win_now[t];
    end
  end

  always_comb begin
    iss_valid   = 1'b0;
    iss_horiz   = 1'b0;
    iss_live    = 1'b0;
    iss_last    = 1'b1;
    iss_rel     = '0;
    iss_top     = '0;
    iss_tmod    = rmod_q;
    rd_col      = col_q;
    wr_en       = 1'b0;
    rel_start   = '0;
    col_d       = col_q;
    row_d       = row_q;
    rmod_d      = rmod_q;
    drain_act_d = drain_act_q;
    drain_col_d = drain_col_q;
    drain_rel_d = drain_rel_q;
    tmod_d      = tmod_q;
    seq_act_d   = seq_act_q;
    seq_rel_d   = seq_rel_q;
    if (seq_act_q) begin
      // rest of a row's tail, one beat per cycle while the queue has room
      if (space) begin
        iss_valid = 1'b1;
        iss_horiz = 1'b1;
        iss_rel   = seq_rel_q;
        iss_top   = TW'(col_last);
        iss_last  = (seq_rel_q == 2'd0);
        if (seq_rel_q == 2'd0) begin
          seq_act_d = 1'b0;
        end else begin
          seq_rel_d = seq_rel_q - 2'd1;
        end
      end
    end else if (acc) begin
      if (is_pix) begin
        drain_act_d = 1'b0;
        if (!dir_q) begin
          if (col_q == col_last) begin
            rel_start = (TW'(col_q) < TW'(h_eff)) ? col_q[1:0] : h_eff;
            iss_valid = 1'b1;
            iss_horiz = 1'b1;
            iss_rel   = rel_start;
            iss_top   = TW'(col_q);
            iss_last  = (rel_start == 2'd0);
            if (rel_start != 2'd0) begin
              seq_act_d = 1'b1;
              seq_rel_d = rel_start - 2'd1;
            end
          end else if (TW'(col_q) >= TW'(h_eff)) begin
            iss_valid = 1'b1;
            iss_horiz = 1'b1;
            iss_rel   = h_eff;
            iss_top   = TW'(col_q);
          end
        end else begin
          wr_en = 1'b1;
          if (TW'(row_q) >= TW'(h_eff)) begin
            iss_valid = 1'b1;
            iss_live  = 1'b1;
            iss_rel   = h_eff;
            iss_top   = TW'(row_q);
          end
          if (frame_end && h_eff != 2'd0) begin
            drain_act_d = 1'b1;
            drain_col_d = '0;
            drain_rel_d = (TW'(row_last) < TW'(h_eff - 2'd1)) ? row_last[1:0]
                                                              : h_eff - 2'd1;
            tmod_d      = rmod_q;
          end
        end
        if (col_q == col_last) begin
          col_d = '0;
          if (row_q == row_last) begin
            row_d  = '0;
            rmod_d = '0;
          end else begin
            row_d  = row_q + 1'b1;
            rmod_d = (rmod_q == BW'(WIN - 1)) ? '0 : rmod_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end else if (dir_q && drain_act_q) begin
        iss_valid = 1'b1;
        iss_rel   = drain_rel_q;
        iss_top   = TW'(row_last);
        iss_tmod  = tmod_q;
        rd_col    = drain_col_q;
        if (drain_col_q == col_last) begin
          drain_col_d = '0;
          if (drain_rel_q == 2'd0) begin
            drain_act_d = 1'b0;
          end else begin
            drain_rel_d = drain_rel_q - 2'd1;
          end
        end else begin
          drain_col_d = drain_col_q + 1'b1;
        end
      end
    end
    if (geo_wr) begin
      col_d       = '0;
      row_d       = '0;
      rmod_d      = '0;
      drain_act_d = 1'b0;
      seq_act_d   = 1'b0;
    end
  end

  // distance of each tap from the newest sample, clamped at both image edges
  always_comb begin
    sum_rh = (BW+1)'(iss_rel) + (BW+1)'(h_eff);
    for (int k = 0; k < WIN; k++) begin
      if (sum_rh <= (BW+1)'(k)) begin
        tap_dist[k] = '0;
      end else begin
        tap_dist[k] = BW'(sum_rh - (BW+1)'(k));
      end
      if (TW'(tap_dist[k]) > iss_top) begin
        tap_dist[k] = BW'(iss_top);
      end
      bank[k]  = (iss_tmod >= tap_dist[k]) ? iss_tmod - tap_dist[k]
                                           : BW'(iss_tmod + BW'(WIN) - tap_dist[k]);
      mask[k]  = ((BW+1)'(k) <= (BW+1)'({h_eff, 1'b0}));
      hsamp[k] = win_src[tap_dist[k]];
    end
  end

  for (genvar b = 0; b < WIN; b++) begin : g_bank
    odic_bank #(
      .DEPTH (MAX_WIDTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (wr_en && (rmod_q == BW'(b))),
      .waddr_i (col_q),
      .wdata_i (pix_i),
      .raddr_i (rd_col),
      .rdata_o (rd_data[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 11'd640;
      height_q    <= 11'd480;
      dir_q       <= 1'b0;
      half_q      <= 2'd1;
      col_q       <= '0;
      row_q       <= '0;
      rmod_q      <= '0;
      drain_act_q <= 1'b0;
      drain_col_q <= '0;
      drain_rel_q <= '0;
      tmod_q      <= '0;
      seq_act_q   <= 1'b0;
      seq_rel_q   <= '0;
      b_valid_q   <= 1'b0;
    end else begin
      if (cfg_i.we) begin
        case (odic_pkg::reg_idx_e'(cfg_i.idx))
          odic_pkg::REG_WIDTH:     width_q  <= cfg_i.data[odic_pkg::DIM_W-1:0];
          odic_pkg::REG_HEIGHT:    height_q <= cfg_i.data[odic_pkg::DIM_W-1:0];
          odic_pkg::REG_DIRECTION: dir_q    <= cfg_i.data[0];
          odic_pkg::REG_HALF:      half_q   <= cfg_i.data[1:0];
          default: ;
        endcase
      end
      col_q       <= col_d;
      row_q       <= row_d;
      rmod_q      <= rmod_d;
      drain_act_q <= drain_act_d;
      drain_col_q <= drain_col_d;
      drain_rel_q <= drain_rel_d;
      tmod_q      <= tmod_d;
      seq_act_q   <= seq_act_d;
      seq_rel_q   <= seq_rel_d;
      b_valid_q   <= iss_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && is_pix && !dir_q) begin
      win_q <= win_now;
    end
    if (iss_valid) begin
      b_horiz_q <= iss_horiz;
      b_last_q  <= iss_last;
      b_pix_q   <= pix_i;
      for (int k = 0; k < WIN; k++) begin
        b_hs_q[k]   <= hsamp[k];
        b_bank_q[k] <= bank[k];
        b_byp_q[k]  <= iss_live && (tap_dist[k] == '0);
        b_mask_q[k] <= mask[k];
      end
    end
  end

  // stage b: bank data is back, build the job
  always_comb begin
    job_o[WIN*PW] = b_last_q;
    for (int k = 0; k < WIN; k++) begin
      if (!b_mask_q[k]) begin
        job_o[k*PW +: PW] = '0;
      end else if (b_horiz_q) begin
        job_o[k*PW +: PW] = b_hs_q[k];
      end else if (b_byp_q[k]) begin
        job_o[k*PW +: PW] = b_pix_q;
      end else begin
        job_o[k*PW +: PW] = rd_data[b_bank_q[k]];
      end
    end
  end

  assign push_o = b_valid_q;

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (32'(q_stat_i.count) < odic_pkg::QUEUE_DEPTH))
    else $error("job push with a full queue");

  a_seq_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_act_q |-> (!dir_q && seq_rel_q < h_eff))
    else $error("row tail sequencing outside horizontal mode");

  a_drain_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_act_q |-> (dir_q && h_eff != 2'd0 && !seq_act_q))
    else $error("drain pending outside vertical mode");

endmodule

// ----- hdl/odic_queue.sv -----
// short job queue between front and back
module odic_queue #(
  parameter int W = 169
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [W-1:0]      data_i,
  input  logic              pop_i,
  output logic [W-1:0]      data_o,
  output odic_pkg::q_stat_t stat_o
);

  localparam int DEPTH = odic_pkg::QUEUE_DEPTH;
  localparam int PTW   = $clog2(DEPTH);
  localparam int CNW   = odic_pkg::QCNT_W;

  logic [W-1:0]   mem_q [DEPTH];
  logic [PTW-1:0] wptr_q, rptr_q;
  logic [CNW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      count_q <= count_q + CNW'(push_i) - CNW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o           = mem_q[rptr_q];
  assign stat_o.count     = count_q;
  assign stat_o.not_empty = (count_q != '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> (32'(count_q) < DEPTH))
    else $error("queue overflow");

endmodule

// ----- hdl/odic_back.sv -----
// back end: coefficient registers, tap multipliers, sum, clamp and output register
module odic_back #(
  parameter int HALF_MAX = odic_pkg::HALF_MAX_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  odic_pkg::cfg_wr_t                         cfg_i,
  input  logic [(2*HALF_MAX+1)*odic_pkg::PIX_W:0]   job_i,
  input  logic                                      job_valid_i,
  output logic                                      pop_o,
  output logic                                      m_valid_o,
  input  logic                                      m_ready_i,
  output logic [odic_pkg::PIX_W-1:0]                m_data_o,
  output logic                                      m_last_o
);

  localparam int WIN   = 2 * HALF_MAX + 1;
  localparam int PW    = odic_pkg::PIX_W;
  localparam int CH    = odic_pkg::CH_W;
  localparam int CFW   = odic_pkg::COEF_W;
  localparam int PRODW = CH + 1 + CFW;
  localparam int SUMW  = PRODW + $clog2(WIN) + 1;
  localparam logic signed [SUMW-1:0] SAT_LIM = SUMW'(255 * (2 ** odic_pkg::COEF_FRAC));

  logic [odic_pkg::CFG_DATA_W-1:0] coef_lo_q, coef_hi_q;
  logic signed [CFW-1:0]   coef [WIN];
  logic signed [PRODW-1:0] prod_q [WIN][3];
  logic signed [SUMW-1:0]  sum [3];
  logic                    s1_valid_q, s1_last_q;
  logic                    out_valid_q, out_last_q;
  logic [PW-1:0]           out_data_q;
  logic                    en;

  function automatic logic [CH-1:0] clamp_ch(input logic signed [SUMW-1:0] s);
    logic [CH-1:0] r;
    if (s < 0) begin
      r = '0;
    end else if (s >= SAT_LIM) begin
      r = '1;
    end else begin
      r = s[odic_pkg::COEF_FRAC +: CH];
    end
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      if (k < 4) begin
        coef[k] = $signed(coef_lo_q[k*CFW +: CFW]);
      end else if (k < 7) begin
        coef[k] = $signed(coef_hi_q[(k-4)*CFW +: CFW]);
      end else begin
        coef[k] = '0;
      end
    end
  end

  // whole pipe moves when the output register is free or being taken
  assign en    = !out_valid_q || m_ready_i;
  assign pop_o = en && job_valid_i;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = '0;
      for (int k = 0; k < WIN; k++) begin
        sum[c] = sum[c] + SUMW'(prod_q[k][c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_lo_q   <= '0;
      coef_hi_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.we) begin
        case (odic_pkg::reg_idx_e'(cfg_i.idx))
          odic_pkg::REG_COEF_LO: coef_lo_q <= cfg_i.data;
          odic_pkg::REG_COEF_HI: coef_hi_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (en) begin
        s1_valid_q  <= job_valid_i;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_last_q <= job_i[WIN*PW];
      for (int k = 0; k < WIN; k++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[k][c] <= $signed({1'b0, job_i[k*PW + c*CH +: CH]}) * coef[k];
        end
      end
    end
    if (en && s1_valid_q) begin
      out_last_q <= s1_last_q;
      for (int c = 0; c < 3; c++) begin
        out_data_q[c*CH +: CH] <= clamp_ch(sum[c]);
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;

endmodule

// ----- hdl/one_dim_image_convolver_unit.sv -----
// top level of the one-dimensional image convolver
//
//  channel  direction  handshake                     payload
//  s_axis   in         s_axis_tvalid/s_axis_tready   tdata blue,green,red; tuser cmd
//  m_axis   out        m_axis_tvalid/m_axis_tready   tdata blue,green,red; tlast run_last
//  cfg      in         cfg_we_i (no wait)            cfg_idx_i, cfg_wdata_i
//
// one input beat per cycle unless the input stalls; a last pixel of a row in horizontal
// mode holds the input while the front issues the rest of the row tail, min(h, width-1)
// more jobs. an input beat reaches the output through issue/bank read, job build,
// multiply, and sum and clamp into the output register.
// the input stalls when the four-entry job queue cannot take the beat in stage b plus
// one more; the back stalls only on m_axis_tready. reset clears counters and queue;
// the line store is never cleared.
module one_dim_image_convolver_unit #(
  parameter int MAX_WIDTH = odic_pkg::MAX_WIDTH_DEF,
  parameter int HALF_MAX  = odic_pkg::HALF_MAX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [odic_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [odic_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [23:0]                         s_axis_tdata,  // in_blue, in_green, in_red
  input  logic                                s_axis_tuser,  // cmd
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [23:0]                         m_axis_tdata,  // out_blue, out_green, out_red
  output logic                                m_axis_tlast
);

  localparam int JOB_W = (2 * HALF_MAX + 1) * odic_pkg::PIX_W + 1;

  odic_pkg::cfg_wr_t cfg;
  odic_pkg::q_stat_t q_stat;
  logic [JOB_W-1:0]  push_job, head_job;
  logic              push, pop;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  odic_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .HALF_MAX  (HALF_MAX)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .cmd_i     (s_axis_tuser),
    .pix_i     (s_axis_tdata),
    .q_stat_i  (q_stat),
    .push_o    (push),
    .job_o     (push_job)
  );

  odic_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_job),
    .pop_i  (pop),
    .data_o (head_job),
    .stat_o (q_stat)
  );

  odic_back #(
    .HALF_MAX (HALF_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_i       (head_job),
    .job_valid_i (q_stat.not_empty),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule
